/* rtl/core/bcdcalc_pkg.sv */
// bcdcalc_pkg: shared widths, constants, stage types and segment decode for the bcd calculator
package bcdcalc_pkg;

  localparam int OperandW = 18;
  localparam int ResultW  = 36;
  localparam int ValueW   = 35;
  localparam int MagW     = 35;
  localparam int BcdDigits = 11;
  localparam int BcdW     = 4 * BcdDigits;
  localparam int SegW     = 7;
  localparam int ShownDigits = 5;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpSub = 2'd1;
  localparam logic [1:0] OpMul = 2'd2;
  localparam logic [1:0] OpDiv = 2'd3;

  localparam logic [1:0] WhichA   = 2'd0;
  localparam logic [1:0] WhichB   = 2'd1;
  localparam logic [1:0] WhichRes = 2'd2;

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatOver = 2'd1;
  localparam logic [1:0] StatDivZ = 2'd2;

  localparam logic signed [ResultW-1:0] Limit  = 36'sd10000;
  localparam logic signed [ResultW-1:0] ValMax = 36'sd17179869183;
  localparam logic signed [ResultW-1:0] ValMin = -36'sd17179869184;

  typedef struct packed {
    logic [1:0]                 op;
    logic signed [OperandW-1:0] a;
    logic signed [OperandW-1:0] b;
    logic                       neg;
    logic [OperandW-1:0]        num;
    logic [OperandW-1:0]        rem;
    logic [OperandW-1:0]        dvs;
    logic signed [ResultW-1:0]  prod;
  } arith_t;

  typedef struct packed {
    logic signed [OperandW-1:0] a;
    logic signed [OperandW-1:0] b;
    logic signed [ResultW-1:0]  r;
    logic [1:0]                 status;
  } calc_t;

  typedef struct packed {
    logic [1:0]                which;
    logic signed [ResultW-1:0] value;
    logic [1:0]                status;
    logic                      last;
    logic                      neg;
    logic [MagW-1:0]           mbits;
    logic [BcdW-1:0]           bcd;
  } conv_t;

  function automatic logic [SegW-1:0] seg7(input logic [3:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7C;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/bcd_calculator_seven_segment.sv */
// bcd_calculator_seven_segment: pipelined signed calculator with seven-segment decimal output
// Accepts one operation (add, subtract, multiply, truncating divide) on two signed 18-bit
// operands and returns three words: operand A, operand B and the result, each with its value,
// a status, DIGITS decimal places as seven-segment patterns and a bad-digit mask. The
// serializer turns each operation into three output words and takes a new operation only
// while it sends the result word of the previous one or is empty. Data passes an 18-stage
// restoring divider, the serializer, a 35-stage binary to bcd shift pipeline and the output
// register. Any stall on the output freezes the whole pipeline without loss.
module bcd_calculator_seven_segment #(
  parameter int DIGITS = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          op_i,
  input  logic signed [bcdcalc_pkg::OperandW-1:0] operand_a_i,
  input  logic signed [bcdcalc_pkg::OperandW-1:0] operand_b_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          which_number_o,
  output logic signed [bcdcalc_pkg::ValueW-1:0] number_value_o,
  output logic [1:0]                          status_o,
  output logic [bcdcalc_pkg::SegW-1:0]        seg_ten_thousands_o,
  output logic [bcdcalc_pkg::SegW-1:0]        seg_thousands_o,
  output logic [bcdcalc_pkg::SegW-1:0]        seg_hundreds_o,
  output logic [bcdcalc_pkg::SegW-1:0]        seg_tens_o,
  output logic [bcdcalc_pkg::SegW-1:0]        seg_units_o,
  output logic [bcdcalc_pkg::ShownDigits-1:0] digit_error_mask_o,
  output logic                                last_o
);
  import bcdcalc_pkg::*;

  localparam int DivSteps = OperandW;
  localparam int ConvSteps = MagW;

  logic en, en_a, ser_free;

  // arithmetic pipeline
  logic [DivSteps:0] av_q;
  arith_t            ap_q [DivSteps+1];
  arith_t            ap_d [DivSteps+1];

  always_comb begin
    ap_d[0].op   = op_i;
    ap_d[0].a    = operand_a_i;
    ap_d[0].b    = operand_b_i;
    ap_d[0].neg  = operand_a_i[OperandW-1] ^ operand_b_i[OperandW-1];
    ap_d[0].num  = operand_a_i[OperandW-1] ? OperandW'(-operand_a_i) : operand_a_i;
    ap_d[0].dvs  = operand_b_i[OperandW-1] ? OperandW'(-operand_b_i) : operand_b_i;
    ap_d[0].rem  = '0;
    ap_d[0].prod = '0;
  end

  for (genvar k = 1; k <= DivSteps; k++) begin : g_div
    logic [OperandW:0] trial;
    logic              ge;
    always_comb begin
      trial = {ap_q[k-1].rem, ap_q[k-1].num[OperandW-1]};
      ge    = trial >= {1'b0, ap_q[k-1].dvs};
      ap_d[k] = ap_q[k-1];
      ap_d[k].rem = ge ? OperandW'(trial - {1'b0, ap_q[k-1].dvs}) : trial[OperandW-1:0];
      ap_d[k].num = {ap_q[k-1].num[OperandW-2:0], ge};
      if (k == 1) begin
        ap_d[k].prod = ResultW'(ap_q[k-1].a) * ResultW'(ap_q[k-1].b);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q <= '0;
    end else if (en_a) begin
      av_q <= {av_q[DivSteps-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      for (int k = 0; k <= DivSteps; k++) begin
        ap_q[k] <= ap_d[k];
      end
    end
  end

  // result selection at the end of the divider
  calc_t                     calc_d;
  logic signed [ResultW-1:0] quo;
  always_comb begin
    quo = ap_q[DivSteps].neg ? -ResultW'({1'b0, ap_q[DivSteps].num})
                             : ResultW'({1'b0, ap_q[DivSteps].num});
    calc_d.a = ap_q[DivSteps].a;
    calc_d.b = ap_q[DivSteps].b;
    calc_d.status = StatOk;
    case (ap_q[DivSteps].op)
      OpAdd: calc_d.r = ResultW'(ap_q[DivSteps].a) + ResultW'(ap_q[DivSteps].b);
      OpSub: calc_d.r = ResultW'(ap_q[DivSteps].a) - ResultW'(ap_q[DivSteps].b);
      OpMul: calc_d.r = ap_q[DivSteps].prod;
      default: begin
        if (ap_q[DivSteps].b == '0) begin
          calc_d.r = '0;
          calc_d.status = StatDivZ;
        end else begin
          calc_d.r = quo;
        end
      end
    endcase
    if (calc_d.status == StatOk && calc_d.r > Limit) begin
      calc_d.status = StatOver;
    end
  end

  // serializer: three words per operation
  logic       ser_vld_q;
  logic [1:0] cnt_q;
  calc_t      ser_q;

  assign ser_free = !ser_vld_q || (cnt_q == WhichRes);
  assign en       = !out_valid_o || out_ready_i;
  assign en_a     = en && ser_free;
  assign in_ready_o = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      cnt_q     <= WhichA;
    end else if (en) begin
      if (ser_free) begin
        ser_vld_q <= av_q[DivSteps];
        cnt_q     <= WhichA;
      end else begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      ser_q <= calc_d;
    end
  end

  // binary to bcd pipeline
  logic [ConvSteps:0] cv_q;
  conv_t              cp_q [ConvSteps+1];
  conv_t              cp_d [ConvSteps+1];

  always_comb begin
    cp_d[0].which  = cnt_q;
    cp_d[0].status = ser_q.status;
    cp_d[0].last   = (cnt_q == WhichRes);
    case (cnt_q)
      WhichA:  cp_d[0].value = ResultW'(ser_q.a);
      WhichB:  cp_d[0].value = ResultW'(ser_q.b);
      default: cp_d[0].value = ser_q.r;
    endcase
    cp_d[0].neg   = cp_d[0].value[ResultW-1];
    cp_d[0].mbits = cp_d[0].neg ? MagW'(-cp_d[0].value) : MagW'(cp_d[0].value);
    cp_d[0].bcd   = '0;
  end

  for (genvar k = 1; k <= ConvSteps; k++) begin : g_dabble
    logic [BcdW-1:0] adj;
    always_comb begin
      for (int j = 0; j < BcdDigits; j++) begin
        adj[4*j +: 4] = (cp_q[k-1].bcd[4*j +: 4] >= 4'd5) ?
                        cp_q[k-1].bcd[4*j +: 4] + 4'd3 : cp_q[k-1].bcd[4*j +: 4];
      end
      cp_d[k] = cp_q[k-1];
      cp_d[k].bcd   = {adj[BcdW-2:0], cp_q[k-1].mbits[MagW-1]};
      cp_d[k].mbits = {cp_q[k-1].mbits[MagW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else if (en) begin
      cv_q <= {cv_q[ConvSteps-1:0], ser_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= ConvSteps; k++) begin
        cp_q[k] <= cp_d[k];
      end
    end
  end

  // segment decode and output register
  conv_t                      fin;
  logic [SegW-1:0]            seg_d [ShownDigits];
  logic [ShownDigits-1:0]     mask_d;
  logic                       hi_zero;
  logic [3:0]                 dg;
  logic signed [ResultW-1:0]  sat;

  always_comb begin
    fin = cp_q[ConvSteps];
    hi_zero = 1'b1;
    for (int j = 0; j < BcdDigits; j++) begin
      if (j >= DIGITS && fin.bcd[4*j +: 4] != 4'd0) begin
        hi_zero = 1'b0;
      end
    end
    mask_d = '0;
    for (int i = 0; i < ShownDigits; i++) begin
      dg = fin.bcd[4*i +: 4];
      seg_d[i] = '0;
      if (fin.status == StatOk && i < DIGITS) begin
        if ((fin.neg && dg != 4'd0) || (i == DIGITS - 1 && !hi_zero)) begin
          mask_d[i] = 1'b1;
        end else begin
          seg_d[i] = seg7(dg);
        end
      end
    end
    if (fin.value > ValMax) begin
      sat = ValMax;
    end else if (fin.value < ValMin) begin
      sat = ValMin;
    end else begin
      sat = fin.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= cv_q[ConvSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      which_number_o      <= fin.which;
      number_value_o      <= sat[ValueW-1:0];
      status_o            <= fin.status;
      seg_units_o         <= seg_d[0];
      seg_tens_o          <= seg_d[1];
      seg_hundreds_o      <= seg_d[2];
      seg_thousands_o     <= seg_d[3];
      seg_ten_thousands_o <= seg_d[4];
      digit_error_mask_o  <= mask_d;
      last_o              <= fin.last;
    end
  end

endmodule

/* tb/sv/tb.sv */
// tb: self-checking testbench for the bcd calculator with seven-segment output
`timescale 1ns / 100ps

module tb;
  import bcdcalc_pkg::*;

  typedef struct packed {
    logic [1:0]          op;
    logic signed [17:0]  a;
    logic signed [17:0]  b;
  } calc_req_t;

  typedef struct packed {
    logic [1:0]         which;
    logic signed [34:0] value;
    logic [1:0]         status;
    logic [6:0]         s4;
    logic [6:0]         s3;
    logic [6:0]         s2;
    logic [6:0]         s1;
    logic [6:0]         s0;
    logic [4:0]         mask;
    logic               last;
  } disp_word_t;

  localparam int StallLimit = 20000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic [1:0] op_i;
  logic signed [17:0] operand_a_i, operand_b_i;
  logic out_valid_o, out_ready_i;
  logic [1:0] which_number_o, status_o;
  logic signed [34:0] number_value_o;
  logic [6:0] seg_ten_thousands_o, seg_thousands_o, seg_hundreds_o, seg_tens_o, seg_units_o;
  logic [4:0] digit_error_mask_o;
  logic last_o;

  calc_req_t  pending_reqs[$];
  disp_word_t expected_words[$];
  int errors = 0;
  int words_seen = 0;
  int reqs_sent = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_off = 0;
  bit stim_done = 0;
  bit hold_done = 0;
  int op_count[4];

  bcd_calculator_seven_segment u_dut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [6:0] digit_seg(longint d);
    case (d)
      0: return 7'h3F;
      1: return 7'h06;
      2: return 7'h5B;
      3: return 7'h4F;
      4: return 7'h66;
      5: return 7'h6D;
      6: return 7'h7C;
      7: return 7'h07;
      8: return 7'h7F;
      default: return 7'h6F;
    endcase
  endfunction

  function automatic disp_word_t display_word(logic [1:0] which, longint v,
                                              logic [1:0] status, bit fin);
    disp_word_t w;
    longint place, rest, k, clip;
    logic [6:0] segs[5];
    place = 10000;
    rest = v;
    w.mask = '0;
    for (int i = 4; i >= 0; i--) begin
      k = rest / place;
      rest -= k * place;
      segs[i] = '0;
      if (status == StatOk) begin
        if (k >= 0 && k <= 9) segs[i] = digit_seg(k);
        else w.mask[i] = 1'b1;
      end
      place /= 10;
    end
    clip = v;
    if (clip > 64'sd17179869183) clip = 64'sd17179869183;
    if (clip < -64'sd17179869184) clip = -64'sd17179869184;
    w.which = which;
    w.value = clip[34:0];
    w.status = status;
    w.s4 = segs[4];
    w.s3 = segs[3];
    w.s2 = segs[2];
    w.s1 = segs[1];
    w.s0 = segs[0];
    w.last = fin;
    return w;
  endfunction

  task automatic predict_display(calc_req_t q);
    longint a, b, r;
    logic [1:0] st;
    a = q.a;
    b = q.b;
    r = 0;
    st = StatOk;
    case (q.op)
      OpAdd: r = a + b;
      OpSub: r = a - b;
      OpMul: r = a * b;
      default: begin
        if (b == 0) st = StatDivZ;
        else r = a / b;
      end
    endcase
    if (st == StatOk && r > 10000) st = StatOver;
    expected_words.push_back(display_word(WhichA, a, st, 0));
    expected_words.push_back(display_word(WhichB, b, st, 0));
    expected_words.push_back(display_word(WhichRes, r, st, 1));
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch on word %0d: %s got %0d expected %0d", words_seen, what, got, want);
  endtask

  function automatic logic signed [17:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 18'(int'($urandom_range(0, 20)) - 10);
      1: return 18'(int'($urandom_range(0, 200)) - 100);
      2: return 18'(int'($urandom_range(0, 19998)) - 9999);
      3: return $urandom_range(0, 1) ? 18'sd99999 : -18'sd99999;
      default: return 18'(int'($urandom_range(0, 199998)) - 99999);
    endcase
  endfunction

  task automatic add_req(logic [1:0] op, int a, int b);
    calc_req_t q;
    q.op = op;
    q.a = 18'(a);
    q.b = 18'(b);
    pending_reqs.push_back(q);
  endtask

  initial begin
    logic [1:0] ops[4];
    ops = '{OpAdd, OpSub, OpMul, OpDiv};
    foreach (ops[i]) begin
      add_req(ops[i], 0, 0);
      add_req(ops[i], 99999, 99999);
      add_req(ops[i], -99999, -99999);
      add_req(ops[i], 12345, -678);
    end
    add_req(OpAdd, 5000, 5000);
    add_req(OpAdd, 5000, 5001);
    add_req(OpMul, -99999, -99999);
    add_req(OpDiv, 7, 0);
    add_req(OpDiv, -7, 2);
    add_req(OpSub, -1, 131071);
    add_req(OpAdd, -131072, 131071);
    for (int i = 0; i < 480; i++) begin
      calc_req_t q;
      q.op = 2'($urandom_range(0, 3));
      q.a = rand_operand();
      q.b = ($urandom_range(0, 15) == 0) ? 18'sd0 : rand_operand();
      if ($urandom_range(0, 19) == 0) q.a = 18'($urandom);
      if ($urandom_range(0, 19) == 0) q.b = 18'($urandom);
      pending_reqs.push_back(q);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i <= '0;
      operand_a_i <= '0;
      operand_b_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_display('{op_i, operand_a_i, operand_b_i});
        op_count[op_i]++;
        reqs_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          calc_req_t q;
          q = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          op_i <= q.op;
          operand_a_i <= q.a;
          operand_b_i <= q.b;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_off <= 0;
      hold_done <= 1'b0;
    end else begin
      if (!hold_done && reqs_sent >= 60) begin
        hold_off <= 400;
        hold_done <= 1'b1;
        out_ready_i <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready_i <= 1'b0;
      end else if ((words_seen / 150) % 2 == 1) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      disp_word_t w;
      words_seen++;
      if (expected_words.size() == 0) begin
        errors++;
        $display("unexpected word %0d", words_seen);
      end else begin
        w = expected_words.pop_front();
        if (which_number_o !== w.which) report_mismatch("which_number", which_number_o, w.which);
        if (number_value_o !== w.value) report_mismatch("number_value", number_value_o, w.value);
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (seg_ten_thousands_o !== w.s4) report_mismatch("seg_ten_thousands", seg_ten_thousands_o, w.s4);
        if (seg_thousands_o !== w.s3) report_mismatch("seg_thousands", seg_thousands_o, w.s3);
        if (seg_hundreds_o !== w.s2) report_mismatch("seg_hundreds", seg_hundreds_o, w.s2);
        if (seg_tens_o !== w.s1) report_mismatch("seg_tens", seg_tens_o, w.s1);
        if (seg_units_o !== w.s0) report_mismatch("seg_units", seg_units_o, w.s0);
        if (digit_error_mask_o !== w.mask) report_mismatch("digit_error_mask", digit_error_mask_o, w.mask);
        if (last_o !== w.last) report_mismatch("last", last_o, w.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && expected_words.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("%0d operations sent (add %0d, sub %0d, mul %0d, div %0d), %0d words checked",
             reqs_sent, op_count[0], op_count[1], op_count[2], op_count[3], words_seen);
    $display("covered operand extremes, over-limit, divide by zero and negative digits");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
